@@ design/sfd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfd_pkg
// Shared constants and types for the sync/XOR frame deframer.
// ----------------------------------------------------------------------------
package sfd_pkg;

    localparam int FRAME_BYTES = 12;
    localparam int BODY_DEPTH  = FRAME_BYTES - 3;
    localparam int CNT_W       = $clog2(FRAME_BYTES);
    localparam int IDX_W       = $clog2(BODY_DEPTH);

    localparam logic [7:0] SYNC_BYTE  = 8'hFF;
    localparam logic [7:0] CHECK_GOOD = 8'h00;

    // Hunt states and the first body position share the byte counter
    localparam logic [CNT_W-1:0] CNT_HUNT   = CNT_W'(0);
    localparam logic [CNT_W-1:0] CNT_SYNC1  = CNT_W'(1);
    localparam logic [CNT_W-1:0] CNT_SYNC2  = CNT_W'(2);
    localparam logic [CNT_W-1:0] CNT_BODY   = CNT_W'(3);
    localparam logic [CNT_W-1:0] CNT_CHECK  = CNT_W'(FRAME_BYTES - 1);

    localparam int RESULT_W = 72;

    typedef struct packed {
        logic [31:0] payload;
        logic [7:0]  data_flag;
        logic [7:0]  reserved_byte;
        logic [7:0]  device_number;
        logic [7:0]  order_code;
        logic [7:0]  header_byte;
    } result_t;

    // Handshake between the core and the output register
    typedef struct packed {
        logic step;
        logic emit;
    } step_ctl_t;

endpackage

@@ design/sfd_in_stage.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfd_in_stage
// Input register: holds one received byte until the core consumes it.
// ----------------------------------------------------------------------------
module sfd_in_stage (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] rx_byte
    input  logic       consume,
    output logic       byte_valid,
    output logic [7:0] byte_data
);
    import sfd_pkg::*;

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] data_reg;

    assign s_tready   = !valid_reg || consume;
    assign byte_valid = valid_reg;
    assign byte_data  = data_reg;

    always_comb begin
        valid_next = valid_reg;
        if (s_tready) begin
            valid_next = s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            data_reg <= s_tdata;
        end
    end

endmodule

@@ design/sfd_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfd_core
// Sync hunt, running XOR check and body byte capture, one byte per step.
// ----------------------------------------------------------------------------
module sfd_core (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 step,
    input  logic [7:0]           rx_byte,
    output logic                 emit,
    output sfd_pkg::result_t     result
);
    import sfd_pkg::*;

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [7:0]       chk_reg;
    logic [7:0]       chk_next;
    logic [7:0]       body_reg [BODY_DEPTH];
    logic             body_we;
    logic [IDX_W-1:0] body_idx;
    logic [7:0]       chk_sum;
    logic             is_sync;
    logic [CNT_W-1:0] pos_idx;

    assign chk_sum = chk_reg ^ rx_byte;
    assign is_sync = (rx_byte == SYNC_BYTE);
    assign pos_idx = count_reg - CNT_SYNC2;

    always_comb begin
        count_next = count_reg;
        chk_next   = chk_reg;
        body_we    = 1'b0;
        body_idx   = '0;
        emit       = 1'b0;
        if (step) begin
            unique case (count_reg)
                CNT_HUNT: begin
                    if (is_sync) begin
                        count_next = CNT_SYNC1;
                    end
                end
                CNT_SYNC1, CNT_SYNC2: begin
                    if (is_sync) begin
                        count_next = CNT_SYNC2;
                    end else begin
                        // take the header; a single sync counts as full
                        count_next = CNT_BODY;
                        chk_next   = chk_sum;
                        body_we    = 1'b1;
                    end
                end
                default: begin
                    if (count_reg >= CNT_CHECK) begin
                        count_next = CNT_HUNT;
                        chk_next   = '0;
                        emit       = (chk_sum == CHECK_GOOD);
                    end else begin
                        count_next = count_reg + CNT_W'(1);
                        chk_next   = chk_sum;
                        body_we    = 1'b1;
                        body_idx   = pos_idx[IDX_W-1:0];
                    end
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= CNT_HUNT;
            chk_reg   <= '0;
        end else begin
            count_reg <= count_next;
            chk_reg   <= chk_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < BODY_DEPTH; i++) begin
            if (body_we && (body_idx == IDX_W'(i))) begin
                body_reg[i] <= rx_byte;
            end
        end
    end

    assign result.header_byte   = body_reg[0];
    assign result.order_code    = body_reg[1];
    assign result.device_number = body_reg[2];
    assign result.reserved_byte = body_reg[3];
    assign result.data_flag     = body_reg[4];
    assign result.payload       = {body_reg[5], body_reg[6], body_reg[7], body_reg[8]};

endmodule

@@ design/sfd_out_stage.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfd_out_stage
// Result register: holds a decoded frame until the sink takes it.
// ----------------------------------------------------------------------------
module sfd_out_stage (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  sfd_pkg::step_ctl_t            ctl,
    input  sfd_pkg::result_t              result,
    output logic                          can_take,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [sfd_pkg::RESULT_W-1:0]  m_tdata
);
    import sfd_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t data_reg;

    assign can_take = !valid_reg || m_tready;
    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;

    always_comb begin
        valid_next = valid_reg;
        if (can_take) begin
            // drop the taken result, load a new one if the step emits
            valid_next = ctl.step && ctl.emit;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (can_take && ctl.step && ctl.emit) begin
            data_reg <= result;
        end
    end

endmodule

@@ design/sync_xor_frame_deframer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sync_xor_frame_deframer
// Byte-serial deframer for 12-byte sync/XOR-checked frames.
// ----------------------------------------------------------------------------
//  channel   direction  width  contents
//  s_*       in         8      rx_byte
//  m_*       out        72     header, order, device, reserved, flag, payload
//
//  One byte per cycle while the result register can take it: a byte is
//  registered on input, then stepped through the hunt/check logic into the
//  result register, loaded when a frame's check byte passes the XOR check.
//  aresetn (synchronous) clears the hunt counter, check and both valid flags.
//  While a result waits on m_tready, one more byte is held on input; then
//  s_tready drops.
// ----------------------------------------------------------------------------
module sync_xor_frame_deframer (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [7:0]                   s_tdata,   // [7:0] rx_byte
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // [7:0] header_byte, [15:8] order_code, [23:16] device_number,
    // [31:24] reserved_byte, [39:32] data_flag, [71:40] payload
    output logic [sfd_pkg::RESULT_W-1:0] m_tdata
);
    import sfd_pkg::*;

    logic      byte_valid;
    logic [7:0] byte_data;
    logic      can_take;
    logic      emit;
    result_t   result;
    step_ctl_t ctl;

    assign ctl.step = byte_valid && can_take;
    assign ctl.emit = emit;

    sfd_in_stage u_in_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .consume    (ctl.step),
        .byte_valid (byte_valid),
        .byte_data  (byte_data)
    );

    sfd_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (ctl.step),
        .rx_byte (byte_data),
        .emit    (emit),
        .result  (result)
    );

    sfd_out_stage u_out_stage (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctl      (ctl),
        .result   (result),
        .can_take (can_take),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

@@ design/sfd_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfd_checker
// Port-level checks for the deframer, bound to the top level.
// ----------------------------------------------------------------------------
module sfd_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_tvalid,
    input logic                         s_tready,
    input logic [7:0]                   s_tdata,
    input logic                         m_tvalid,
    input logic                         m_tready,
    input logic [sfd_pkg::RESULT_W-1:0] m_tdata
);
    import sfd_pkg::*;

    // no result may be left over from before reset
    a_reset_clears_out: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // input side is open after reset
    a_reset_opens_in: assert property (@(posedge aclk)
        !aresetn |=> s_tready)
        else $error("input not ready after reset");

    // input backpressure only comes from a stalled result
    a_stall_source: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("input stalled without a stalled result");

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result changed");

endmodule

bind sync_xor_frame_deframer sfd_checker u_sfd_checker (.*);
